// ===== hw/rtl/pesa_pkg.sv =====
// ----------------------------------------------------------------------------
// pesa_pkg: shared types and constants of the execute stage ALU.
// Holds the operation and instruction-kind codes and the stream payload layouts.
// ----------------------------------------------------------------------------
package pesa_pkg;

  // ALU operation selector codes.
  typedef enum logic [3:0] {
    ALU_NONE  = 4'd0,
    ALU_ADD   = 4'd1,
    ALU_SUB   = 4'd2,
    ALU_MUL   = 4'd3,
    ALU_AND   = 4'd4,
    ALU_ORI   = 4'd5,
    ALU_SLL   = 4'd6,
    ALU_SRL   = 4'd7,
    ALU_PASSB = 4'd8
  } alu_sel_e;

  // Instruction kind codes.
  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_JEQ   = 2'd1,
    KIND_JMP   = 2'd2,
    KIND_MEM   = 2'd3
  } instr_kind_e;

  localparam int unsigned XLEN        = 32;
  localparam int unsigned JUMP_W      = 28;
  localparam int unsigned SHAMT_W     = 5;
  localparam int unsigned IN_DATA_W   = 168;
  localparam int unsigned IN_USER_W   = 7;
  localparam int unsigned OUT_DATA_W  = 136;
  localparam logic [XLEN-1:0] PC_TOP_MASK = 32'hF000_0000;

  // Input tdata layout, lowest field last in the declaration.
  typedef struct packed {
    logic [6:0]         pad;
    logic [JUMP_W-1:0]  jump_field;
    logic [XLEN-1:0]    instr_pc;
    logic [SHAMT_W-1:0] shift_amount;
    logic [XLEN-1:0]    imm_value;
    logic [XLEN-1:0]    second_operand;
    logic [XLEN-1:0]    first_operand;
  } in_data_t;

  // Input tuser layout.
  typedef struct packed {
    logic [1:0] instr_kind;
    logic [3:0] alu_sel;
    logic       stage_valid;
  } in_user_t;

  // Output tdata layout.
  typedef struct packed {
    logic [1:0]      pad;
    logic            mem_fields_valid;
    logic [XLEN-1:0] mem_wdata;
    logic [XLEN-1:0] mem_addr;
    logic [XLEN-1:0] branch_target;
    logic            branch_taken;
    logic            overflow_flag;
    logic            carry_flag;
    logic            negative_flag;
    logic            zero_flag;
    logic [XLEN-1:0] alu_out;
  } out_data_t;

endpackage

// ===== hw/rtl/pipeline_execute_stage_alu_top.sv =====
// Each result passes the input register and then the result register.
// Throughput: one instruction per cycle while the result stream is not stalled;
// the 32x32 low-word multiplier between the two registers sets the critical path.
// Slots with stage_valid low are taken and dropped, producing no result.
// Reset clears both valid bits asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// pipeline_execute_stage_alu_top: execute stage of a 32-bit pipelined core.
// Computes the ALU result and flags, branch decision and target, memory fields.
// ----------------------------------------------------------------------------
module pipeline_execute_stage_alu_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // first_operand, second_operand, imm_value, shift_amount, instr_pc,
  // jump_field, zero padding
  input  logic [pesa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // stage_valid, alu_sel, instr_kind
  input  logic [pesa_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // alu_out, zero_flag, negative_flag, carry_flag, overflow_flag, branch_taken,
  // branch_target, mem_addr, mem_wdata, mem_fields_valid, zero padding
  output logic [pesa_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  pesa_pkg::in_data_t  in_data_q;
  pesa_pkg::in_user_t  in_user_q;
  logic                in_valid_q;
  logic                out_valid_q;
  pesa_pkg::out_data_t out_data_q;
  pesa_pkg::out_data_t res_d;
  pesa_pkg::in_user_t  s_user;

  logic                out_load;
  logic                in_load;

  logic [pesa_pkg::XLEN-1:0] a, b, imm, pc, r;
  logic [pesa_pkg::XLEN:0]   add_sum;
  logic [pesa_pkg::XLEN-1:0] sub_diff;
  logic [2*pesa_pkg::XLEN-1:0] mul_full;
  logic                      carry, ovf;

  assign s_user = pesa_pkg::in_user_t'(s_axis_tuser);

  // Handshake: the result register loads when empty or drained, the input
  // register when empty or moving forward.
  assign out_load      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  // Input register; empty slots are dropped at the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= in_load && s_user.stage_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_data_q <= pesa_pkg::in_data_t'(s_axis_tdata);
      in_user_q <= s_user;
    end
  end

  assign a   = in_data_q.first_operand;
  assign b   = in_data_q.second_operand;
  assign imm = in_data_q.imm_value;
  assign pc  = in_data_q.instr_pc;

  assign add_sum  = {1'b0, a} + {1'b0, b};
  assign sub_diff = a - b;
  assign mul_full = a * b;

  // ALU operation select.
  always_comb begin
    r     = '0;
    carry = 1'b0;
    ovf   = 1'b0;
    unique case (pesa_pkg::alu_sel_e'(in_user_q.alu_sel))
      pesa_pkg::ALU_ADD: begin
        r     = add_sum[pesa_pkg::XLEN-1:0];
        carry = add_sum[pesa_pkg::XLEN];
        ovf   = (a[31] ~^ b[31]) && (a[31] ^ add_sum[31]);
      end
      pesa_pkg::ALU_SUB: begin
        r   = sub_diff;
        ovf = (a[31] ^ b[31]) && (a[31] ^ sub_diff[31]);
      end
      pesa_pkg::ALU_MUL:   r = mul_full[pesa_pkg::XLEN-1:0];
      pesa_pkg::ALU_AND:   r = a & b;
      pesa_pkg::ALU_ORI:   r = a | imm;
      pesa_pkg::ALU_SLL:   r = a << in_data_q.shift_amount;
      pesa_pkg::ALU_SRL:   r = a >> in_data_q.shift_amount;
      pesa_pkg::ALU_PASSB: r = b;
      default:             r = '0;
    endcase
  end

  // Result assembly: flags, branch and memory fields.
  always_comb begin
    res_d               = '0;
    res_d.alu_out       = r;
    res_d.zero_flag     = (r == '0);
    res_d.negative_flag = r[pesa_pkg::XLEN-1];
    res_d.carry_flag    = carry;
    res_d.overflow_flag = ovf;
    unique case (pesa_pkg::instr_kind_e'(in_user_q.instr_kind))
      pesa_pkg::KIND_JEQ: begin
        if (a == b) begin
          res_d.branch_taken  = 1'b1;
          res_d.branch_target = pc + pesa_pkg::XLEN'(1) + imm;
        end
      end
      pesa_pkg::KIND_JMP: begin
        res_d.branch_taken  = 1'b1;
        res_d.branch_target = (pc & pesa_pkg::PC_TOP_MASK) |
                              {{(pesa_pkg::XLEN-pesa_pkg::JUMP_W){1'b0}},
                               in_data_q.jump_field};
      end
      pesa_pkg::KIND_MEM: begin
        res_d.mem_fields_valid = 1'b1;
        res_d.mem_addr         = a + imm;
        res_d.mem_wdata        = b;
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      out_data_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/pesa_checker.sv =====
// ----------------------------------------------------------------------------
// pesa_checker: port-level checks of the execute stage ALU.
// Watches result consistency and output stall behavior.
// ----------------------------------------------------------------------------
module pesa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pesa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  pesa_pkg::out_data_t res;
  assign res = pesa_pkg::out_data_t'(m_axis_tdata);

  // A stalled result stays offered with the same payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Zero and negative flags follow the ALU result.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.zero_flag == (res.alu_out == '0)) &&
                      (res.negative_flag == res.alu_out[pesa_pkg::XLEN-1]))
    else $error("zero or negative flag inconsistent with result");

  // Memory fields are cleared for non-memory instructions.
  a_mem_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.mem_fields_valid |-> res.mem_addr == '0 && res.mem_wdata == '0)
    else $error("memory fields set without a memory move");

  // A branch and a memory move never come from one instruction, and an
  // untaken branch carries no target.
  a_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res.branch_taken && res.mem_fields_valid) &&
                      (res.branch_taken || res.branch_target == '0))
    else $error("branch fields inconsistent");

  // Carry and overflow together imply an add with both operands negative,
  // so the result cannot be negative.
  a_carry_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.carry_flag && res.overflow_flag |-> !res.negative_flag)
    else $error("carry and overflow disagree with result sign");

endmodule

bind pipeline_execute_stage_alu_top pesa_checker u_pesa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/pipeline_execute_stage_alu_top_test.sv =====
// ----------------------------------------------------------------------------
// pipeline_execute_stage_alu_top_test: self-checking bench for the execute stage.
// Instructions go in on the slave stream with random gaps and results leave on
// the master stream under random back-pressure. Each result is compared field
// by field against a local model of the ALU, branch and memory-address logic.
// ----------------------------------------------------------------------------
module pipeline_execute_stage_alu_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Selector codes that the stage treats as no operation.
  localparam logic [3:0] ALU_SEL_SPARE_LO = 4'd9;
  localparam logic [3:0] ALU_SEL_SPARE_HI = 4'd15;

  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 400;
  // Cycles to let the pipeline settle once nothing is outstanding.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_INSTRS = 1500;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  // first_operand, second_operand, imm_value, shift_amount, instr_pc,
  // jump_field, zero padding
  logic [pesa_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  // stage_valid, alu_sel, instr_kind
  logic [pesa_pkg::IN_USER_W-1:0] s_axis_tuser = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  // alu_out, zero_flag, negative_flag, carry_flag, overflow_flag, branch_taken,
  // branch_target, mem_addr, mem_wdata, mem_fields_valid, zero padding
  logic [pesa_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  pesa_pkg::out_data_t exec_results_q[$];

  int n_errors = 0;
  int n_sent = 0;
  int n_dropped = 0;
  int n_checked = 0;
  int n_taken = 0;
  int n_mem = 0;
  int idle_cycles = 0;
  int source_quiet_left = 0;
  int sink_quiet_left = 0;

  pipeline_execute_stage_alu_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Computes what the stage should produce for one valid instruction.
  function automatic pesa_pkg::out_data_t compute_execute_result(pesa_pkg::in_user_t u,
                                                                 pesa_pkg::in_data_t d);
    pesa_pkg::out_data_t res;
    logic [32:0] wide;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    a = d.first_operand;
    b = d.second_operand;
    res = '0;
    r = '0;
    case (u.alu_sel)
      pesa_pkg::ALU_ADD: begin
        wide = {1'b0, a} + {1'b0, b};
        r = wide[31:0];
        res.carry_flag = wide[32];
        res.overflow_flag = (a[31] ^ r[31]) & (b[31] ^ r[31]);
      end
      pesa_pkg::ALU_SUB: begin
        r = a - b;
        res.overflow_flag = (a[31] ^ b[31]) & (a[31] ^ r[31]);
      end
      pesa_pkg::ALU_MUL:   r = a * b;
      pesa_pkg::ALU_AND:   r = a & b;
      pesa_pkg::ALU_ORI:   r = a | d.imm_value;
      pesa_pkg::ALU_SLL:   r = a << d.shift_amount;
      pesa_pkg::ALU_SRL:   r = a >> d.shift_amount;
      pesa_pkg::ALU_PASSB: r = b;
      default:             r = '0;
    endcase
    res.alu_out = r;
    res.zero_flag = (r == '0);
    res.negative_flag = r[31];

    // Branch decision and memory fields depend on the instruction kind and operands, not on the ALU selector.
    case (u.instr_kind)
      pesa_pkg::KIND_JEQ: begin
        if (a == b) begin
          res.branch_taken = 1'b1;
          res.branch_target = d.instr_pc + 32'd1 + d.imm_value;
        end
      end
      pesa_pkg::KIND_JMP: begin
        res.branch_taken = 1'b1;
        res.branch_target = (d.instr_pc & pesa_pkg::PC_TOP_MASK) | {4'b0, d.jump_field};
      end
      pesa_pkg::KIND_MEM: begin
        res.mem_fields_valid = 1'b1;
        res.mem_addr = a + d.imm_value;
        res.mem_wdata = b;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Idle cycles before the next transfer; occasionally a long run with none.
  function automatic int draw_wait(ref int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  // Operand values biased toward the arithmetic boundaries.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(0, 15);
      5: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp, act);
      n_errors++;
    end
  endfunction

  // Offers one instruction and waits for its transfer; records the expected result of a valid one.
  task automatic send_instr(input bit valid, input logic [3:0] sel, input logic [1:0] kind,
                            input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] imm, input logic [4:0] sh,
                            input logic [31:0] pc, input logic [27:0] jf);
    pesa_pkg::in_data_t d;
    pesa_pkg::in_user_t u;
    int gap;
    d = '0;
    d.first_operand = a;
    d.second_operand = b;
    d.imm_value = imm;
    d.shift_amount = sh;
    d.instr_pc = pc;
    d.jump_field = jf;
    u.stage_valid = valid;
    u.alu_sel = sel;
    u.instr_kind = kind;
    gap = draw_wait(source_quiet_left);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= u;
    do @(posedge clk_i); while (!s_axis_tready);
    if (valid) begin
      exec_results_q.push_back(compute_execute_result(u, d));
      n_sent++;
    end else begin
      n_dropped++;
    end
  endtask

  // Every operation with boundary operands, including the overflow corners.
  task automatic test_alu_corners();
    send_instr(1'b1, pesa_pkg::ALU_ADD, pesa_pkg::KIND_OTHER, 32'h7FFF_FFFF, 32'h0000_0001,
               0, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_ADD, pesa_pkg::KIND_OTHER, 32'h8000_0000, 32'h8000_0000,
               0, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_ADD, pesa_pkg::KIND_OTHER, 32'hFFFF_FFFF, 32'h0000_0001,
               0, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_ADD, pesa_pkg::KIND_OTHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               0, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_SUB, pesa_pkg::KIND_OTHER, 32'h8000_0000, 32'h0000_0001,
               0, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_SUB, pesa_pkg::KIND_OTHER, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               0, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_SUB, pesa_pkg::KIND_OTHER, 32'h0000_0000, 32'h0000_0000,
               0, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_MUL, pesa_pkg::KIND_OTHER, 32'hFFFF_FFFF, 32'h8000_0000,
               0, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_AND, pesa_pkg::KIND_OTHER, 32'hFFFF_FFFF, 32'hA5A5_5A5A,
               0, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_ORI, pesa_pkg::KIND_OTHER, 32'h0000_0000, 32'h0,
               32'h8000_0000, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_SLL, pesa_pkg::KIND_OTHER, 32'hFFFF_FFFF, 32'h0,
               0, 5'd31, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_SRL, pesa_pkg::KIND_OTHER, 32'hFFFF_FFFF, 32'h0,
               0, 5'd31, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_SRL, pesa_pkg::KIND_OTHER, 32'h8000_0000, 32'h0,
               0, 5'd0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_PASSB, pesa_pkg::KIND_OTHER, 32'h0, 32'h8000_0000,
               0, 0, 0, 0);
    // No operation and the spare selectors all give a zero result.
    send_instr(1'b1, pesa_pkg::ALU_NONE, pesa_pkg::KIND_OTHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               0, 0, 0, 0);
    send_instr(1'b1, ALU_SEL_SPARE_LO, pesa_pkg::KIND_OTHER, 32'h1, 32'h1, 0, 0, 0, 0);
    send_instr(1'b1, ALU_SEL_SPARE_HI, pesa_pkg::KIND_OTHER, 32'h1, 32'h1, 0, 0, 0, 0);
    // An empty slot is taken but yields nothing.
    send_instr(1'b0, pesa_pkg::ALU_ADD, pesa_pkg::KIND_MEM, 32'h1, 32'h1, 32'h1, 0, 0, 0);
  endtask

  // Jumps, taken and untaken compares, and memory address formation.
  task automatic test_control_transfers();
    send_instr(1'b1, pesa_pkg::ALU_SUB, pesa_pkg::KIND_JEQ, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 0);
    send_instr(1'b1, pesa_pkg::ALU_SUB, pesa_pkg::KIND_JEQ, 32'h1234_5678, 32'h1234_5678,
               32'h8000_0000, 0, 32'h0000_0000, 0);
    send_instr(1'b1, pesa_pkg::ALU_SUB, pesa_pkg::KIND_JEQ, 32'h0000_0001, 32'h0000_0002,
               32'h0000_0004, 0, 32'h0000_0100, 0);
    send_instr(1'b1, pesa_pkg::ALU_NONE, pesa_pkg::KIND_JMP, 32'h0, 32'h0, 0, 0,
               32'hFFFF_FFFF, 28'h0000000);
    send_instr(1'b1, pesa_pkg::ALU_NONE, pesa_pkg::KIND_JMP, 32'h0, 32'h0, 0, 0,
               32'h0FFF_FFFF, 28'hFFFFFFF);
    send_instr(1'b1, pesa_pkg::ALU_ADD, pesa_pkg::KIND_MEM, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               32'h0000_0001, 0, 0, 0);
    send_instr(1'b1, pesa_pkg::ALU_ADD, pesa_pkg::KIND_MEM, 32'h8000_0000, 32'h0000_0000,
               32'hFFFF_FFFF, 0, 0, 0);
  endtask

  // Long random instruction stream with boundary-biased operands.
  task automatic test_random_mix();
    int         n_valid;
    bit         valid;
    logic [3:0] sel;
    logic [1:0] kind;
    logic [31:0] a;
    logic [31:0] b;
    n_valid = 0;
    while (n_valid < RANDOM_INSTRS) begin
      valid = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 7) == 0) begin
        sel = 4'($urandom_range(ALU_SEL_SPARE_LO, ALU_SEL_SPARE_HI));
      end else begin
        sel = 4'($urandom_range(pesa_pkg::ALU_NONE, pesa_pkg::ALU_PASSB));
      end
      kind = 2'($urandom_range(pesa_pkg::KIND_OTHER, pesa_pkg::KIND_MEM));
      a = pick_word();
      b = (kind == pesa_pkg::KIND_JEQ && $urandom_range(0, 1)) ? a : pick_word();
      send_instr(valid, sel, kind, a, b, pick_word(), 5'($urandom_range(0, 31)), $urandom(),
                 28'($urandom()));
      if (valid) begin
        n_valid++;
      end
    end
  endtask

  // Result side: random back-pressure once reset is released.
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = draw_wait(sink_quiet_left);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each result transfer with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    pesa_pkg::out_data_t got;
    pesa_pkg::out_data_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (exec_results_q.size() == 0) begin
        $error("result with no instruction outstanding: tdata 0x%h", m_axis_tdata);
        n_errors++;
      end else begin
        exp = exec_results_q.pop_front();
        check_field("alu_out", exp.alu_out, got.alu_out);
        check_field("zero_flag", 32'(exp.zero_flag), 32'(got.zero_flag));
        check_field("negative_flag", 32'(exp.negative_flag), 32'(got.negative_flag));
        check_field("carry_flag", 32'(exp.carry_flag), 32'(got.carry_flag));
        check_field("overflow_flag", 32'(exp.overflow_flag), 32'(got.overflow_flag));
        check_field("branch_taken", 32'(exp.branch_taken), 32'(got.branch_taken));
        check_field("branch_target", exp.branch_target, got.branch_target);
        check_field("mem_addr", exp.mem_addr, got.mem_addr);
        check_field("mem_wdata", exp.mem_wdata, got.mem_wdata);
        check_field("mem_fields_valid", 32'(exp.mem_fields_valid),
                    32'(got.mem_fields_valid));
        n_checked++;
        if (exp.branch_taken) begin
          n_taken++;
        end
        if (exp.mem_fields_valid) begin
          n_mem++;
        end
      end
    end
  end

  // Hang detection: too long without a transfer on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d cycles without a transfer", idle_cycles);
      $display("pipeline_execute_stage_alu_top_test: done, errors");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_alu_corners();
    test_control_transfers();
    test_random_mix();
    s_axis_tvalid <= 1'b0;
    while (exec_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d instructions and %0d empty slots; %0d results checked",
             n_sent, n_dropped, n_checked);
    $display("of those, %0d taken branches and %0d memory moves", n_taken, n_mem);
    if (n_errors == 0) begin
      $display("pipeline_execute_stage_alu_top_test: done, clean");
    end else begin
      $display("pipeline_execute_stage_alu_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== pipeline_execute_stage_alu_top.f =====
hw/rtl/pesa_pkg.sv
hw/rtl/pipeline_execute_stage_alu_top.sv
hw/rtl/pesa_checker.sv
verif/pipeline_execute_stage_alu_top_test.sv
